// ----- src/dhbpwm_pkg.sv -----
// Shared types and constants for the dual H-bridge sign-magnitude PWM.
// No dependencies; every other file in src takes its names from here.
package dhbpwm_pkg;

  localparam int unsigned SpeedW    = 8;
  localparam int unsigned MagW      = 7;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned CountW    = 8;
  localparam int unsigned SpeedMax  = 100;
  localparam int unsigned DutyFull  = 255;

  // Reciprocal of the percent scale: floor(x * RecipMul / 2**RecipShift)
  // equals floor(x / 100) for every x up to 255 * 100.
  localparam int unsigned ScaledW    = 15;
  localparam int unsigned RecipW     = 13;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned RecipMul   = 5243;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  // Per-channel pin pair, forward in bit 0 and reverse in bit 1.
  typedef struct packed {
    logic rev;
    logic fwd;
  } chan_pins_t;

  typedef struct packed {
    chan_pins_t right;
    chan_pins_t left;
  } drive_t;

endpackage

// ----- src/dhbpwm_if.sv -----
// Handshake channels of the dual H-bridge PWM: speed items in, pin states out.
// Depends on dhbpwm_pkg for the operation code type.
interface dhbpwm_in_if;
  import dhbpwm_pkg::*;

  logic              valid;
  logic              ready;
  op_e               op;
  logic signed [7:0] left_speed;
  logic signed [7:0] right_speed;

  modport source (output valid, op, left_speed, right_speed, input ready);
  modport sink   (input valid, op, left_speed, right_speed, output ready);
endinterface

interface dhbpwm_out_if;
  logic valid;
  logic ready;
  logic left_forward_drive;
  logic left_reverse_drive;
  logic right_forward_drive;
  logic right_reverse_drive;

  modport source (output valid, left_forward_drive, left_reverse_drive,
                  right_forward_drive, right_reverse_drive, input ready);
  modport sink   (input valid, left_forward_drive, left_reverse_drive,
                  right_forward_drive, right_reverse_drive, output ready);
endinterface

// ----- src/dual_hbridge_signed_pwm.sv -----
// Top level of the two-channel sign-magnitude PWM for a pair of H-bridges.
// Depends on dhbpwm_pkg and the channel interfaces in dhbpwm_if.sv.
//
//   channel | direction | payload                                   | transfer when
//   in_i    | sink      | op, left_speed, right_speed               | valid & ready
//   out_o   | source    | left/right forward/reverse drive pins     | valid & ready
//
// One item is taken per clock while ready is high; its result is queued in the buffer.
// The pin state is updated in a single registered pass: clamp, duty scaling and counter
// compare all sit between the accepted item and the state registers.
// Results queue in a two-entry output buffer, so input ready only drops when both
// entries hold results that the sink has not yet taken.
// Reset clears the counter, duties, directions and pins, and empties the buffer.
module dual_hbridge_signed_pwm (
  input  logic         clk_i,
  input  logic         rst_ni,
  dhbpwm_in_if.sink    in_i,
  dhbpwm_out_if.source out_o
);
  import dhbpwm_pkg::*;

  // PWM state. A channel's direction is kept as the pin pair that its sign selects,
  // which is all the wrap and compare rules need of the stored level.
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [DutyW-1:0]  left_duty_q, left_duty_d;
  logic [DutyW-1:0]  right_duty_q, right_duty_d;
  chan_pins_t        left_dir_q, left_dir_d;
  chan_pins_t        right_dir_q, right_dir_d;
  drive_t            pins_q, pins_d;

  // Output buffer: entry 0 is the head shown on out_o.
  drive_t            buf_q [2];
  drive_t            buf_d [2];
  logic [1:0]        fill_q, fill_d;

  logic in_xfer;
  logic out_xfer;

  assign in_i.ready = (fill_q != 2'd2);
  assign in_xfer    = in_i.valid & in_i.ready;
  assign out_xfer   = out_o.valid & out_o.ready;

  // Direction pins for a signed percent. Clamping never changes the sign, so the
  // raw speed selects the same pin as the clamped level would.
  function automatic chan_pins_t dir_of(input logic signed [SpeedW-1:0] s);
    chan_pins_t p;
    p.fwd = (s > 0);
    p.rev = (s < 0);
    return p;
  endfunction

  // Clamp a signed percent to the legal range and return its magnitude.
  function automatic logic [MagW-1:0] mag_of(input logic signed [SpeedW-1:0] s);
    logic signed [SpeedW-1:0] lim;
    logic [SpeedW-1:0]        a;
    lim = s;
    if (s > $signed(SpeedW'(SpeedMax))) begin
      lim = $signed(SpeedW'(SpeedMax));
    end else if (s < -$signed(SpeedW'(SpeedMax))) begin
      lim = -$signed(SpeedW'(SpeedMax));
    end
    a = (lim < 0) ? SpeedW'(-lim) : SpeedW'(lim);
    return a[MagW-1:0];
  endfunction

  // Duty = floor(255 * magnitude / 100), with the division done as a reciprocal multiply.
  function automatic logic [DutyW-1:0] duty_of(input logic [MagW-1:0] m);
    logic [ScaledW-1:0]        scaled;
    logic [ScaledW+RecipW-1:0] prod;
    scaled = ScaledW'(m) * ScaledW'(DutyFull);
    prod   = (ScaledW+RecipW)'(scaled) * (ScaledW+RecipW)'(RecipMul);
    return prod[RecipShift +: DutyW];
  endfunction

  always_comb begin
    cnt_d        = cnt_q;
    left_duty_d  = left_duty_q;
    right_duty_d = right_duty_q;
    left_dir_d   = left_dir_q;
    right_dir_d  = right_dir_q;
    pins_d       = pins_q;
    if (in_xfer) begin
      case (in_i.op)
        OP_LOAD: begin
          left_dir_d   = dir_of(in_i.left_speed);
          right_dir_d  = dir_of(in_i.right_speed);
          left_duty_d  = duty_of(mag_of(in_i.left_speed));
          right_duty_d = duty_of(mag_of(in_i.right_speed));
          cnt_d        = '0;
          pins_d       = '0;
        end
        default: begin
          // A tick: the wrap raises the active pin, then a duty match lowers it.
          cnt_d = cnt_q + CountW'(1);
          if (cnt_d == '0) begin
            pins_d.left  = pins_d.left | left_dir_q;
            pins_d.right = pins_d.right | right_dir_q;
          end
          if (cnt_d == left_duty_q) begin
            pins_d.left = pins_d.left & ~left_dir_q;
          end
          if (cnt_d == right_duty_q) begin
            pins_d.right = pins_d.right & ~right_dir_q;
          end
        end
      endcase
    end
  end

  // Output buffer bookkeeping: pop shifts the tail forward, push lands behind it.
  always_comb begin
    logic [1:0] held;
    held     = fill_q - {1'b0, out_xfer};
    buf_d[0] = out_xfer ? buf_q[1] : buf_q[0];
    buf_d[1] = buf_q[1];
    if (in_xfer) begin
      if (held == 2'd0) begin
        buf_d[0] = pins_d;
      end else begin
        buf_d[1] = pins_d;
      end
    end
    fill_d = held + {1'b0, in_xfer};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      left_duty_q  <= '0;
      right_duty_q <= '0;
      left_dir_q   <= '0;
      right_dir_q  <= '0;
      pins_q       <= '0;
      fill_q       <= '0;
    end else begin
      cnt_q        <= cnt_d;
      left_duty_q  <= left_duty_d;
      right_duty_q <= right_duty_d;
      left_dir_q   <= left_dir_d;
      right_dir_q  <= right_dir_d;
      pins_q       <= pins_d;
      fill_q       <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q[0] <= buf_d[0];
    buf_q[1] <= buf_d[1];
  end

  assign out_o.valid               = (fill_q != 2'd0);
  assign out_o.left_forward_drive  = buf_q[0].left.fwd;
  assign out_o.left_reverse_drive  = buf_q[0].left.rev;
  assign out_o.right_forward_drive = buf_q[0].right.fwd;
  assign out_o.right_reverse_drive = buf_q[0].right.rev;

  // The buffer never holds more than its two entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q != 2'd3)
    else $error("output buffer over-filled");

  // A bridge never has both of its pins driven at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pins_q.left.fwd && pins_q.left.rev) && !(pins_q.right.fwd && pins_q.right.rev))
    else $error("both pins of one bridge driven");

  // A load transfer restarts the period with every pin low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.op == OP_LOAD |=> cnt_q == '0 && pins_q == '0)
    else $error("load did not restart the period");

  // Without a transfer on either side the buffer level holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer && !out_xfer |=> $stable(fill_q))
    else $error("buffer level moved without a transfer");

  // The pin state changes only when an input item is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(pins_q) && $stable(cnt_q))
    else $error("PWM state moved without an input transfer");

endmodule

// ----- tb/dual_hbridge_signed_pwm_tb.sv -----
// Self-checking testbench for the dual H-bridge sign-magnitude PWM block.
// Depends on dhbpwm_pkg and the channel interfaces in dhbpwm_if.sv; reads nothing else.
module dual_hbridge_signed_pwm_tb;
  import dhbpwm_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  dhbpwm_in_if  in_ch ();
  dhbpwm_out_if out_ch ();

  dual_hbridge_signed_pwm uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Our own copy of the PWM state, advanced once for every accepted item.
  logic [CountW-1:0]        period_count;
  logic signed [SpeedW-1:0] left_level;
  logic signed [SpeedW-1:0] right_level;
  logic [DutyW-1:0]         left_duty;
  logic [DutyW-1:0]         right_duty;
  drive_t                   pins_now;

  // Pin states still owed by the block, oldest first.
  drive_t expected_pins[$];

  int failures        = 0;
  int results_checked = 0;
  int loads_sent      = 0;
  int ticks_sent      = 0;
  int wraps_driven    = 0;
  int pulses_ended    = 0;

  // When clear, the corresponding side of the handshake never idles.
  bit send_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Speeds outside the percent range are pinned to the nearest end of it.
  function automatic logic signed [SpeedW-1:0] clamp_percent(logic signed [SpeedW-1:0] s);
    int v;
    v = int'(s);
    if (v < -int'(SpeedMax)) v = -int'(SpeedMax);
    if (v > int'(SpeedMax)) v = int'(SpeedMax);
    return v[SpeedW-1:0];
  endfunction

  // Compare value: full scale times the magnitude, divided by 100 and truncated.
  function automatic logic [DutyW-1:0] duty_from_level(logic signed [SpeedW-1:0] lvl);
    int mag;
    int scaled;
    mag    = (lvl < 0) ? -int'(lvl) : int'(lvl);
    scaled = (int'(DutyFull) * mag) / int'(SpeedMax);
    return scaled[DutyW-1:0];
  endfunction

  // The pin that a channel drives for its present direction; none at zero speed.
  function automatic chan_pins_t active_pin(logic signed [SpeedW-1:0] lvl);
    chan_pins_t p;
    p.fwd = (lvl > 0);
    p.rev = (lvl < 0);
    return p;
  endfunction

  task automatic step_pwm_model(op_e op, logic signed [SpeedW-1:0] l_speed,
                                logic signed [SpeedW-1:0] r_speed);
    if (op == OP_LOAD) begin
      // A load restarts the period with every pin low.
      left_level   = clamp_percent(l_speed);
      right_level  = clamp_percent(r_speed);
      left_duty    = duty_from_level(left_level);
      right_duty   = duty_from_level(right_level);
      period_count = '0;
      pins_now     = '0;
      loads_sent++;
    end else begin
      // The speeds carried by a tick are ignored.
      period_count = period_count + 1'b1;
      ticks_sent++;
      // The wrap raises the pins first, so that a compare on the same count wins.
      if (period_count == '0) begin
        pins_now.left  = pins_now.left | active_pin(left_level);
        pins_now.right = pins_now.right | active_pin(right_level);
        if (left_level != 0 || right_level != 0) wraps_driven++;
      end
      if (period_count == left_duty && pins_now.left != '0) begin
        pins_now.left = pins_now.left & ~active_pin(left_level);
        pulses_ended++;
      end
      if (period_count == right_duty && pins_now.right != '0) begin
        pins_now.right = pins_now.right & ~active_pin(right_level);
        pulses_ended++;
      end
    end
    expected_pins.push_back(pins_now);
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Mostly back-to-back transfers, some short pauses and the odd long one.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Sends one item and returns at the edge on which its transfer took place.
  // Valid is left high, so a following item can go out on the very next cycle.
  task automatic send_item(op_e op, logic signed [SpeedW-1:0] l_speed,
                           logic signed [SpeedW-1:0] r_speed);
    int gap;
    gap = pick_gap(send_gaps_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.left_speed  <= l_speed;
    in_ch.right_speed <= r_speed;
    do @(posedge clk); while (!in_ch.ready);
    step_pwm_model(op, l_speed, r_speed);
  endtask

  function automatic logic signed [SpeedW-1:0] random_byte();
    return SpeedW'($urandom_range(0, 255));
  endfunction

  // Speeds for a load: a blend of the whole byte range, the clamp edges and tiny values.
  function automatic logic signed [SpeedW-1:0] pick_speed();
    int edges[8] = '{-128, -101, -100, -99, 99, 100, 101, 127};
    int v;
    case ($urandom_range(0, 3))
      0, 1: return random_byte();
      2: begin
        v = edges[$urandom_range(0, 7)];
        return v[SpeedW-1:0];
      end
      default: begin
        v = $urandom_range(0, 10) - 5;
        return v[SpeedW-1:0];
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // The sink accepts in bursts and stalls in between, now and then for a long while.
  initial begin
    int stall;
    int burst;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_gap(sink_stalls_on);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      burst = $urandom_range(1, 24);
      repeat (burst) @(posedge clk);
    end
  end

  task automatic check_pin(string field, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      failures++;
    end
  endtask

  // Every result transfer is matched against the oldest outstanding pin state.
  always @(posedge clk) begin
    drive_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_pins.size() == 0) begin
        $error("result transfer with no item outstanding");
        failures++;
      end else begin
        want = expected_pins.pop_front();
        check_pin("left_forward_drive", want.left.fwd, out_ch.left_forward_drive);
        check_pin("left_reverse_drive", want.left.rev, out_ch.left_reverse_drive);
        check_pin("right_forward_drive", want.right.fwd, out_ch.right_forward_drive);
        check_pin("right_reverse_drive", want.right.rev, out_ch.right_reverse_drive);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset both levels are zero, so ticks must leave every pin low,
  // whatever speeds happen to ride along with them.
  task automatic test_idle_after_reset();
    send_item(OP_TICK, 8'sd127, -8'sd128);
    send_item(OP_TICK, -8'sd128, 8'sd127);
    send_item(OP_TICK, 8'sd0, 8'sd0);
  endtask

  // Loads across the clamp boundaries, each followed by a tick. Every load result
  // shows all pins low; so does the tick, since the counter has not yet wrapped.
  task automatic test_speed_clamping();
    int pairs[9][2] = '{'{-128, 127}, '{-101, 101}, '{-100, 100}, '{-99, 99},
                        '{-1, 1}, '{0, 0}, '{1, -1}, '{127, -128}, '{100, -100}};
    foreach (pairs[i]) begin
      send_item(OP_LOAD, pairs[i][0][SpeedW-1:0], pairs[i][1][SpeedW-1:0]);
      send_item(OP_TICK, random_byte(), random_byte());
    end
  endtask

  // Loads followed by runs of ticks, most of them long enough to cross one or more
  // counter wraps so that pulses start and end. The load after a long run interrupts a
  // period, sometimes while a pin is high; a short run ends before the first wrap.
  task automatic test_random_pwm(int n_items);
    int sent;
    int run;
    sent = 0;
    while (sent < n_items) begin
      // The first stretch runs without any idling on either side.
      send_gaps_on   = (sent >= n_items / 3);
      sink_stalls_on = (sent >= n_items / 3);
      send_item(OP_LOAD, pick_speed(), pick_speed());
      sent++;
      run = ($urandom_range(0, 9) < 4) ? $urandom_range(1, 60) : $urandom_range(256, 620);
      // The last run is cut short so the item count stays at the requested total.
      if (run > n_items - sent) run = n_items - sent;
      repeat (run) begin
        send_item(OP_TICK, random_byte(), random_byte());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_TICK;
    in_ch.left_speed  <= '0;
    in_ch.right_speed <= '0;
    rst_n             <= 1'b0;
    period_count = '0;
    left_level   = '0;
    right_level  = '0;
    left_duty    = '0;
    right_duty   = '0;
    pins_now     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_after_reset();
    test_speed_clamping();
    test_random_pwm(1750);

    in_ch.valid <= 1'b0;
    send_gaps_on   = 1'b1;
    sink_stalls_on = 1'b1;
    while (expected_pins.size() != 0) @(posedge clk);
    // Keep the clock running after the queue drains, so that any stray result transfer is caught.
    repeat (8) @(posedge clk);

    $display("Covered %0d loads and %0d ticks; %0d results compared.",
             loads_sent, ticks_sent, results_checked);
    $display("Saw %0d counter wraps with a pin raised and %0d pulses ended by compare.",
             wraps_driven, pulses_ended);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
